/* hdl/rmv_pkg.sv */
package rmv_pkg;

  // Arithmetic widths.
  localparam int SAMPLE_BITS   = 30;
  localparam int FRACTION_BITS = 16;
  localparam int COUNT_BITS    = 16;
  localparam int MEAN_BITS     = SAMPLE_BITS + FRACTION_BITS;
  localparam int SQ_BITS       = 63;
  localparam int NUM_CH        = 4;
  localparam int CH_IDX_BITS   = $clog2(NUM_CH);

  // Port field widths.
  localparam int TIME_W     = 30;
  localparam int OUT_COUNT_W = 16;
  localparam int IN_DATA_W  = ((NUM_CH * TIME_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = OUT_COUNT_W + NUM_CH * (MEAN_BITS + SQ_BITS);
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Serial divider: four quotient bits per cycle.
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_CYCLES     = (MEAN_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_W          = DIV_CYCLES * DIV_RADIX_BITS;
  localparam int DIV_CNT_BITS   = $clog2(DIV_CYCLES + 1);

  // Serial multiplier: operands split into two halves, four partial products.
  localparam int MUL_HALF = (MEAN_BITS + 1) / 2;
  localparam int MUL_OP_W = 2 * MUL_HALF;
  localparam int PROD_W   = 2 * MUL_OP_W;
  localparam int INC_W    = PROD_W - 2 * FRACTION_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SQ_BITS-1:0]    SQ_MAX    = '1;

  typedef logic [CH_IDX_BITS-1:0] ch_t;

  // One state memory entry: running mean and sum of squared deviations.
  typedef struct packed {
    logic [MEAN_BITS-1:0] mean;
    logic [SQ_BITS-1:0]   sq;
  } entry_t;

  // Write request into the state memory.
  typedef struct packed {
    logic   we;
    ch_t    addr;
    entry_t data;
  } ram_wr_t;

endpackage

/* hdl/rmv_state_ram.sv */
module rmv_state_ram (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  rmv_pkg::ram_wr_t wr,
  input  rmv_pkg::ch_t     rd_addr,
  output rmv_pkg::entry_t  rd_data
);

  rmv_pkg::entry_t             mem [rmv_pkg::NUM_CH];
  logic [rmv_pkg::NUM_CH-1:0]  valid_r;
  rmv_pkg::entry_t             rd_q_r;
  logic                        rd_valid_r;

  // Storage array, one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Per-entry valid bits; an entry not written since reset or a group start reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (clear) begin
        valid_r <= '0;
      end
      if (wr.we) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr] && !clear;
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

/* hdl/rmv_divider.sv */
module rmv_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rmv_pkg::MEAN_BITS-1:0]  dividend,
  input  logic [rmv_pkg::COUNT_BITS-1:0] divisor,
  output logic                           done,
  output logic [rmv_pkg::MEAN_BITS-1:0]  quotient
);

  logic [rmv_pkg::DIV_W-1:0]        quo_r, quo_nxt;
  logic [rmv_pkg::COUNT_BITS-1:0]   rem_r, rem_nxt;
  logic [rmv_pkg::COUNT_BITS-1:0]   den_r;
  logic [rmv_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;

  // Four restoring steps per cycle; dividend bits shift out the top as quotient bits enter.
  always_comb begin
    logic [rmv_pkg::COUNT_BITS:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < rmv_pkg::DIV_RADIX_BITS; k++) begin
      trial   = {rem_nxt, quo_nxt[rmv_pkg::DIV_W-1]};
      quo_nxt = {quo_nxt[rmv_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial      = trial - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[rmv_pkg::COUNT_BITS-1:0];
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rmv_pkg::DIV_CNT_BITS'(rmv_pkg::DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= rmv_pkg::DIV_W'(dividend);
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[rmv_pkg::MEAN_BITS-1:0];

endmodule

/* hdl/rmv_multiplier.sv */
module rmv_multiplier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rmv_pkg::MEAN_BITS-1:0] op_a,
  input  logic [rmv_pkg::MEAN_BITS-1:0] op_b,
  output logic                          done,
  output logic [rmv_pkg::PROD_W-1:0]    product
);

  localparam int H = rmv_pkg::MUL_HALF;

  logic [rmv_pkg::MUL_OP_W-1:0] a_r, b_r;
  logic [1:0]                   step_r;
  logic                         run_r;
  logic [rmv_pkg::MUL_OP_W-1:0] pp_r;
  logic [1:0]                   pp_pos_r;
  logic                         pp_valid_r;
  logic                         pp_last_r;
  logic                         done_r;
  logic [rmv_pkg::PROD_W-1:0]   acc_r;
  logic [H-1:0]                 a_part, b_part;
  logic [rmv_pkg::PROD_W-1:0]   pp_shifted;

  // Half-word operand selection for the current partial product.
  assign a_part = step_r[1] ? a_r[2*H-1:H] : a_r[H-1:0];
  assign b_part = step_r[0] ? b_r[2*H-1:H] : b_r[H-1:0];

  // Align the registered partial product by its half-word position.
  always_comb begin
    case (pp_pos_r)
      2'd0:    pp_shifted = rmv_pkg::PROD_W'(pp_r);
      2'd1:    pp_shifted = rmv_pkg::PROD_W'(pp_r) << H;
      2'd2:    pp_shifted = rmv_pkg::PROD_W'(pp_r) << (2 * H);
      default: pp_shifted = '0;
    endcase
  end

  // Sequencing of the partial products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      step_r     <= '0;
      pp_valid_r <= 1'b0;
      pp_last_r  <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r     <= pp_valid_r && pp_last_r;
      pp_valid_r <= run_r;
      pp_last_r  <= run_r && (step_r == 2'd3);
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 2'd3) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // One half-by-half product per cycle, accumulated the cycle after.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= rmv_pkg::MUL_OP_W'(op_a);
      b_r <= rmv_pkg::MUL_OP_W'(op_b);
    end
    pp_r     <= a_part * b_part;
    pp_pos_r <= 2'(step_r[1]) + 2'(step_r[0]);
    if (start) begin
      acc_r <= '0;
    end else if (pp_valid_r) begin
      acc_r <= acc_r + pp_shifted;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

/* hdl/running_mean_variance_top.sv */
// Running mean and sum of squared deviations over four timing channels
// (count, scan, store and wall durations in ns), updated by Welford's rule.
//
// The input channel carries one timing record per request; in_tuser set
// starts a new group, clearing the count, means and sums before the
// sample is folded in. Each accepted request produces exactly one result
// request: the sample count and the four means (Q30.16) and four sums.
//
// The four channels are processed one after another through a shared
// serial divider (four quotient bits per cycle) and a serial multiplier
// (four 23x23 partial products), with the state held in a four-entry
// memory that is read, updated and written back per channel. A new
// record is accepted once the previous one has left the datapath.
// A finished result waits in the output register while the receiver
// stalls; the next record is still accepted and computed, and only its
// final hand-off waits for the output register to empty.
// Reset clears the count and marks every memory entry as zero.
module running_mean_variance_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: count_time, scan_time, store_time, wall_time.
  input  logic [rmv_pkg::IN_DATA_W-1:0]   in_tdata,
  // Fields from bit 0: start_group.
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: samples_seen, count_mean, scan_mean, store_mean,
  // wall_mean, count_sq_dev, scan_sq_dev, store_sq_dev, wall_sq_dev, zero pad.
  output logic [rmv_pkg::OUT_DATA_W-1:0]  out_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MEAN,
    ST_MUL,
    ST_PUSH
  } state_t;

  state_t                           state_r;
  rmv_pkg::ch_t                     ch_r;
  logic [rmv_pkg::SAMPLE_BITS-1:0]  x_r [rmv_pkg::NUM_CH];
  logic [rmv_pkg::COUNT_BITS-1:0]   total_r;
  logic [rmv_pkg::COUNT_BITS-1:0]   total_base;
  logic [rmv_pkg::COUNT_BITS-1:0]   divisor;
  logic [rmv_pkg::MEAN_BITS-1:0]    mean_r, newmean_r, d_r;
  logic [rmv_pkg::SQ_BITS-1:0]      sq_r;
  logic                             up_r;

  logic [rmv_pkg::COUNT_BITS-1:0]   res_count_r;
  logic [rmv_pkg::MEAN_BITS-1:0]    res_mean_r [rmv_pkg::NUM_CH];
  logic [rmv_pkg::SQ_BITS-1:0]      res_sq_r [rmv_pkg::NUM_CH];
  logic                             out_valid_r;
  logic [rmv_pkg::COUNT_BITS-1:0]   out_count_r;
  logic [rmv_pkg::MEAN_BITS-1:0]    out_mean_r [rmv_pkg::NUM_CH];
  logic [rmv_pkg::SQ_BITS-1:0]      out_sq_r [rmv_pkg::NUM_CH];

  logic                             in_accept;
  logic [rmv_pkg::MEAN_BITS-1:0]    x_cur;
  logic                             up_c;
  logic [rmv_pkg::MEAN_BITS-1:0]    d_c;
  logic [rmv_pkg::MEAN_BITS-1:0]    newmean_c;
  logic [rmv_pkg::MEAN_BITS-1:0]    e_c;
  logic [rmv_pkg::INC_W-1:0]        inc_c;
  logic [rmv_pkg::SQ_BITS:0]        sum_c;
  logic [rmv_pkg::SQ_BITS-1:0]      sum_sat;

  rmv_pkg::ram_wr_t                 ram_wr;
  rmv_pkg::ch_t                     ram_rd_addr;
  logic                             ram_rd_en;
  rmv_pkg::entry_t                  ram_rd;
  logic                             div_start, div_done;
  logic [rmv_pkg::MEAN_BITS-1:0]    div_q;
  logic                             mul_start, mul_done;
  logic [rmv_pkg::PROD_W-1:0]       mul_p;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Count after this sample, saturating; a group start counts from zero.
  assign total_base = in_tuser ? '0 : total_r;
  assign divisor    = (total_r == '0) ? rmv_pkg::COUNT_BITS'(1) : total_r;

  // Current sample in mean format and its deviation from the stored mean.
  assign x_cur = {x_r[ch_r], rmv_pkg::FRACTION_BITS'(0)};
  assign up_c  = (x_cur >= ram_rd.mean);
  assign d_c   = up_c ? (x_cur - ram_rd.mean) : (ram_rd.mean - x_cur);

  // Mean step rounds toward zero; new mean stays between old mean and sample.
  assign newmean_c = up_r ? (mean_r + div_q) : (mean_r - div_q);
  assign e_c       = up_r ? (x_cur - newmean_r) : (newmean_r - x_cur);

  // Whole part of the product; both terms stay below 2^63, so overflow shows in the top bit.
  assign inc_c   = mul_p[rmv_pkg::PROD_W-1:2*rmv_pkg::FRACTION_BITS];
  assign sum_c   = {1'b0, sq_r} + (rmv_pkg::SQ_BITS + 1)'(inc_c);
  assign sum_sat = sum_c[rmv_pkg::SQ_BITS] ? rmv_pkg::SQ_MAX : sum_c[rmv_pkg::SQ_BITS-1:0];

  // Memory requests: write back a finished channel while reading the next one.
  // The write request packs enable, address, mean and sum from the top bit down.
  assign div_start       = (state_r == ST_LOAD);
  assign mul_start       = (state_r == ST_MEAN);
  assign ram_wr          = {(state_r == ST_MUL) && mul_done, ch_r, newmean_r, sum_sat};
  assign ram_rd_en       = in_accept || (ram_wr.we && (ch_r != rmv_pkg::ch_t'(rmv_pkg::NUM_CH - 1)));
  assign ram_rd_addr     = in_accept ? '0 : ch_r + 1'b1;

  rmv_state_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (in_accept && in_tuser),
    .wr      (ram_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd)
  );

  rmv_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (d_c),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  rmv_multiplier u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (d_r),
    .op_b    (e_c),
    .done    (mul_done),
    .product (mul_p)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_PUSH) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            total_r <= (total_base == rmv_pkg::COUNT_MAX) ? total_base : total_base + 1'b1;
            ch_r    <= '0;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            if (ch_r == rmv_pkg::ch_t'(rmv_pkg::NUM_CH - 1)) begin
              state_r <= ST_PUSH;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= ST_LOAD;
            end
          end
        end
        ST_PUSH: begin
          if (!out_valid_r || out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < rmv_pkg::NUM_CH; i++) begin
        x_r[i] <= rmv_pkg::SAMPLE_BITS'(in_tdata[i*rmv_pkg::TIME_W +: rmv_pkg::TIME_W]);
      end
    end
    if (state_r == ST_LOAD) begin
      mean_r <= ram_rd.mean;
      sq_r   <= ram_rd.sq;
      up_r   <= up_c;
      d_r    <= d_c;
    end
    if ((state_r == ST_DIV) && div_done) begin
      newmean_r <= newmean_c;
    end
    if (ram_wr.we) begin
      res_mean_r[ch_r] <= newmean_r;
      res_sq_r[ch_r]   <= sum_sat;
      res_count_r      <= total_r;
    end
    if ((state_r == ST_PUSH) && (!out_valid_r || out_tready)) begin
      out_count_r <= res_count_r;
      out_mean_r  <= res_mean_r;
      out_sq_r    <= res_sq_r;
    end
  end

  // Result packing.
  always_comb begin
    out_tdata = '0;
    out_tdata[rmv_pkg::OUT_COUNT_W-1:0] = rmv_pkg::OUT_COUNT_W'(out_count_r);
    for (int i = 0; i < rmv_pkg::NUM_CH; i++) begin
      out_tdata[rmv_pkg::OUT_COUNT_W + i*rmv_pkg::MEAN_BITS +: rmv_pkg::MEAN_BITS] =
        out_mean_r[i];
      out_tdata[rmv_pkg::OUT_COUNT_W + rmv_pkg::NUM_CH*rmv_pkg::MEAN_BITS
                + i*rmv_pkg::SQ_BITS +: rmv_pkg::SQ_BITS] = out_sq_r[i];
    end
  end

  assign out_tvalid = out_valid_r;

  // The write-back and the read of the next channel never address the same entry.
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr.we && ram_rd_en) |-> (ram_wr.addr != ram_rd_addr))
    else $error("state memory read and write hit the same entry");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside its wait state");

  // The multiplier only finishes while the sequencer waits for it.
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL))
    else $error("multiplier finished outside its wait state");

  // Every sample being folded in has a nonzero count.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (total_r != '0))
    else $error("sample count is zero after acceptance");

endmodule
